/* rtl/core/r2q_pkg.sv */
// Shared constants, types and table functions for the rotation-vector-to-quaternion core.
package r2q_pkg;

  // Fixed-point constants in Q.30
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
  localparam int unsigned        MAX_STAGES  = 32;

  // Datapath widths
  localparam int unsigned SUMW  = 66;  // sum of three squares
  localparam int unsigned ROOTW = 33;  // integer square root of the sum
  localparam int unsigned CW    = 36;  // CORDIC x, y and angle
  localparam int unsigned NUMW  = 64;  // |rc| * |sin|

  // Payload that travels beside the arithmetic in every cell
  typedef struct packed {
    logic [31:0] trans_x;
    logic [31:0] trans_y;
    logic [31:0] trans_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } side_t;

  // Unsigned quotient by shift and subtract, used only for elaboration-time constants
  function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[63:0], num[j]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[j] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arc tangent of 2^-i in Q.30, series form, rounded half up
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] t;
    int unsigned e;
    acc = '0;
    if (i == 0) return CW'(36'sd843314857);
    for (int unsigned k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        t = udiv_const(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k[0]) acc = acc - t;
        else acc = acc + t;
      end
    end
    acc = (acc + (64'd1 << 31)) >> 32;
    return CW'(acc);
  endfunction

  // Elaboration-time integer square root for the gain constant
  function automatic logic [63:0] isqrt_const(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_q;
    logic [63:0] rem;
    res = '0;
    rem = v;
    bit_q = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bit_q != 0 && bit_q <= v) begin
        if (rem >= res + bit_q) begin
          rem = rem - (res + bit_q);
          res = (res >> 1) + bit_q;
        end else begin
          res = res >> 1;
        end
      end else if (bit_q != 0) begin
        res = res;
      end
      bit_q = bit_q >> 2;
    end
    return res;
  endfunction

  // CORDIC start value: inverse of the accumulated gain, Q.30
  function automatic logic signed [CW-1:0] cordic_gain(input int unsigned stages);
    logic [63:0] a;
    logic [63:0] s;
    a = 64'd1 << 60;
    for (int unsigned i = 0; i < MAX_STAGES; i++) begin
      if (i < stages) a = a + (a >> (2 * i));
    end
    s = isqrt_const(a);
    return CW'(udiv_const((64'd1 << 60) + (s >> 1), s));
  endfunction

endpackage

/* rtl/core/r2q_sqrt_cell.sv */
// Restoring square-root chain cell: one root bit per cycle while en_i is high.
module r2q_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [r2q_pkg::SUMW-1:0]        rem_i,
  input  logic [r2q_pkg::SUMW-1:0]        root_i,
  input  r2q_pkg::side_t                  side_i,
  output logic                            valid_o,
  output logic [r2q_pkg::SUMW-1:0]        rem_o,
  output logic [r2q_pkg::SUMW-1:0]        root_o,
  output r2q_pkg::side_t                  side_o
);

  localparam int unsigned Shift = 2 * (r2q_pkg::ROOTW - 1 - Step);
  localparam logic [r2q_pkg::SUMW-1:0] BitV = r2q_pkg::SUMW'(1) << Shift;

  logic [r2q_pkg::SUMW-1:0] trial;
  logic                     take;
  logic                     valid_q;
  logic [r2q_pkg::SUMW-1:0] rem_q, rem_d, root_q, root_d;
  r2q_pkg::side_t           side_q;

  // Trial subtract of the running root plus the current bit
  always_comb begin
    trial = root_i + BitV;
    take  = (rem_i >= trial);
    rem_d  = take ? rem_i - trial : rem_i;
    root_d = take ? (root_i >> 1) + BitV : (root_i >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

/* rtl/core/r2q_cordic_cell.sv */
// Rotation-mode CORDIC cell: one micro-rotation per en_i cycle.
module r2q_cordic_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [r2q_pkg::CW-1:0]     x_i,
  input  logic signed [r2q_pkg::CW-1:0]     y_i,
  input  logic signed [r2q_pkg::CW-1:0]     z_i,
  input  logic [r2q_pkg::ROOTW-1:0]         n_i,
  input  logic                              negc_i,
  input  r2q_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [r2q_pkg::CW-1:0]     x_o,
  output logic signed [r2q_pkg::CW-1:0]     y_o,
  output logic signed [r2q_pkg::CW-1:0]     z_o,
  output logic [r2q_pkg::ROOTW-1:0]         n_o,
  output logic                              negc_o,
  output r2q_pkg::side_t                    side_o
);

  localparam logic signed [r2q_pkg::CW-1:0] AtanV = r2q_pkg::atan_q30(Step);

  logic signed [r2q_pkg::CW-1:0] xs, ys;
  logic signed [r2q_pkg::CW-1:0] x_d, y_d, z_d, x_q, y_q, z_q;
  logic                          valid_q, negc_q;
  logic [r2q_pkg::ROOTW-1:0]     n_q;
  r2q_pkg::side_t                side_q;

  // Rotate toward zero residual angle
  always_comb begin
    xs = x_i >>> Step;
    ys = y_i >>> Step;
    if (!z_i[r2q_pkg::CW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - AtanV;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + AtanV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      n_q    <= n_i;
      negc_q <= negc_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign n_o     = n_q;
  assign negc_o  = negc_q;
  assign side_o  = side_q;

endmodule

/* rtl/core/r2q_div_cell.sv */
// One restoring divider-chain cell, three vector parts: one quotient bit per cycle while enabled.
module r2q_div_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [r2q_pkg::ROOTW-1:0]      n_i,
  input  logic [2:0][r2q_pkg::NUMW:0]    rem_i,
  input  logic [2:0][r2q_pkg::NUMW-1:0]  num_i,
  input  logic [2:0][r2q_pkg::NUMW-1:0]  quo_i,
  input  logic [2:0]                     neg_i,
  input  logic [r2q_pkg::CW-1:0]         w_i,
  input  logic                           zero_i,
  input  r2q_pkg::side_t                 side_i,
  output logic                           valid_o,
  output logic [r2q_pkg::ROOTW-1:0]      n_o,
  output logic [2:0][r2q_pkg::NUMW:0]    rem_o,
  output logic [2:0][r2q_pkg::NUMW-1:0]  num_o,
  output logic [2:0][r2q_pkg::NUMW-1:0]  quo_o,
  output logic [2:0]                     neg_o,
  output logic [r2q_pkg::CW-1:0]         w_o,
  output logic                           zero_o,
  output r2q_pkg::side_t                 side_o
);

  logic [2:0][r2q_pkg::NUMW:0]   rem_d, rem_q;
  logic [2:0][r2q_pkg::NUMW-1:0] num_d, num_q, quo_d, quo_q;
  logic [r2q_pkg::NUMW:0]        sh;
  logic                          valid_q, zero_q;
  logic [2:0]                    neg_q;
  logic [r2q_pkg::ROOTW-1:0]     n_q;
  logic [r2q_pkg::CW-1:0]        w_q;
  r2q_pkg::side_t                side_q;

  // Shift in the next numerator bit and try to subtract the divisor
  always_comb begin
    sh = '0;
    for (int c = 0; c < 3; c++) begin
      sh = {rem_i[c][r2q_pkg::NUMW-1:0], num_i[c][r2q_pkg::NUMW-1]};
      num_d[c] = num_i[c] << 1;
      if (sh >= (r2q_pkg::NUMW + 1)'(n_i)) begin
        rem_d[c] = sh - (r2q_pkg::NUMW + 1)'(n_i);
        quo_d[c] = {quo_i[c][r2q_pkg::NUMW-2:0], 1'b1};
      end else begin
        rem_d[c] = sh;
        quo_d[c] = {quo_i[c][r2q_pkg::NUMW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      num_q  <= num_d;
      quo_q  <= quo_d;
      n_q    <= n_i;
      neg_q  <= neg_i;
      w_q    <= w_i;
      zero_q <= zero_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign quo_o   = quo_q;
  assign neg_o   = neg_q;
  assign w_o     = w_q;
  assign zero_o  = zero_q;
  assign side_o  = side_q;

endmodule

/* rtl/core/rotvec_to_quaternion_core.sv */
// Top level: rotation vector and translation in, position and unit quaternion out.
//
//  Channel   Dir  Bus          Contents
//  s_axis    in   tdata 192b   rot_x, rot_y, rot_z, trans_x, trans_y, trans_z
//  m_axis    out  tdata 224b   pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
//
// One beat is taken per cycle while the chain is not halted; a beat passes through the
// square-root, CORDIC and divider cell chains (one bit or one micro-rotation per
// cell). Reset clears only the valid bits of the chain.
// The whole chain advances together and halts when the output holds a beat that
// is not taken; s_axis_tready is high whenever the chain can advance.
module rotvec_to_quaternion_core #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // rot_x, rot_y, rot_z, trans_x, trans_y, trans_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [223:0] m_axis_tdata    // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
);

  localparam int unsigned SW = r2q_pkg::SUMW;
  localparam int unsigned RW = r2q_pkg::ROOTW;
  localparam int unsigned CW = r2q_pkg::CW;
  localparam int unsigned NW = r2q_pkg::NUMW;
  localparam logic signed [CW-1:0] GainV = r2q_pkg::cordic_gain(CORDIC_STAGES);

  logic en;
  logic out_valid_q;

  // The chain moves when the output register is free or being emptied
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- Stage 0: squares ----------------
  r2q_pkg::side_t side_in;
  assign side_in.rot_x   = s_axis_tdata[31:0];
  assign side_in.rot_y   = s_axis_tdata[63:32];
  assign side_in.rot_z   = s_axis_tdata[95:64];
  assign side_in.trans_x = s_axis_tdata[127:96];
  assign side_in.trans_y = s_axis_tdata[159:128];
  assign side_in.trans_z = s_axis_tdata[191:160];

  logic [31:0] ux, uy, uz;
  assign ux = side_in.rot_x[31] ? 32'(-side_in.rot_x) : 32'(side_in.rot_x);
  assign uy = side_in.rot_y[31] ? 32'(-side_in.rot_y) : 32'(side_in.rot_y);
  assign uz = side_in.rot_z[31] ? 32'(-side_in.rot_z) : 32'(side_in.rot_z);

  logic           sq_valid_q;
  logic [63:0]    sqx_q, sqy_q, sqz_q;
  r2q_pkg::side_t sq_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else if (en) begin
      sq_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q     <= ux * ux;
      sqy_q     <= uy * uy;
      sqz_q     <= uz * uz;
      sq_side_q <= side_in;
    end
  end

  // Sum of squares
  logic           sum_valid_q;
  logic [SW-1:0]  sum_q;
  r2q_pkg::side_t sum_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (en) begin
      sum_valid_q <= sq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q      <= SW'(sqx_q) + SW'(sqy_q) + SW'(sqz_q);
      sum_side_q <= sq_side_q;
    end
  end

  // ---------------- Square-root chain ----------------
  logic [RW:0]                sv;
  logic [RW:0][SW-1:0]        srem, sroot;
  r2q_pkg::side_t [RW:0]      sside;

  assign sv[0]    = sum_valid_q;
  assign srem[0]  = sum_q;
  assign sroot[0] = '0;
  assign sside[0] = sum_side_q;

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    r2q_sqrt_cell #(.Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(sv[g]), .rem_i(srem[g]), .root_i(sroot[g]), .side_i(sside[g]),
      .valid_o(sv[g+1]), .rem_o(srem[g+1]), .root_o(sroot[g+1]), .side_o(sside[g+1])
    );
  end

  // ---------------- Range reduction ----------------
  logic [RW-1:0]          nroot;
  logic signed [CW-1:0]   a0, a1, a2;
  logic                   negc_d;
  assign nroot = sroot[RW][RW-1:0];

  always_comb begin
    a0 = CW'({nroot, 1'b0});
    a1 = (a0 > r2q_pkg::PI_Q30) ? a0 - r2q_pkg::TWO_PI_Q30 : a0;
    negc_d = 1'b0;
    a2 = a1;
    if (a1 > r2q_pkg::HALF_PI_Q30) begin
      a2 = r2q_pkg::PI_Q30 - a1;
      negc_d = 1'b1;
    end else if (a1 < -r2q_pkg::HALF_PI_Q30) begin
      a2 = -r2q_pkg::PI_Q30 - a1;
      negc_d = 1'b1;
    end
  end

  logic           rr_valid_q, rr_negc_q;
  logic signed [CW-1:0] rr_a_q;
  logic [RW-1:0]  rr_n_q;
  r2q_pkg::side_t rr_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rr_valid_q <= 1'b0;
    end else if (en) begin
      rr_valid_q <= sv[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_a_q    <= a2;
      rr_negc_q <= negc_d;
      rr_n_q    <= nroot;
      rr_side_q <= sside[RW];
    end
  end

  // ---------------- CORDIC chain ----------------
  logic [CORDIC_STAGES:0]                  cv, cneg;
  logic signed [CORDIC_STAGES:0][CW-1:0]   cx, cy, cz;
  logic [CORDIC_STAGES:0][RW-1:0]          cn;
  r2q_pkg::side_t [CORDIC_STAGES:0]        cside;

  assign cv[0]    = rr_valid_q;
  assign cx[0]    = GainV;
  assign cy[0]    = '0;
  assign cz[0]    = rr_a_q;
  assign cn[0]    = rr_n_q;
  assign cneg[0]  = rr_negc_q;
  assign cside[0] = rr_side_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    r2q_cordic_cell #(.Step(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(cv[g]), .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .n_i(cn[g]),
      .negc_i(cneg[g]), .side_i(cside[g]),
      .valid_o(cv[g+1]), .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]), .n_o(cn[g+1]),
      .negc_o(cneg[g+1]), .side_o(cside[g+1])
    );
  end

  // ---------------- Products |rc| * |sin| ----------------
  logic signed [CW-1:0] cos_v, sin_v, w_sat;
  logic [31:0]          sin_mag;
  logic [2:0][31:0]     rmag;
  logic [2:0]           rneg;

  always_comb begin
    cos_v = cneg[CORDIC_STAGES] ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
    sin_v = cy[CORDIC_STAGES];
    if (cos_v > r2q_pkg::ONE_Q30) w_sat = r2q_pkg::ONE_Q30;
    else if (cos_v < -r2q_pkg::ONE_Q30) w_sat = -r2q_pkg::ONE_Q30;
    else w_sat = cos_v;
    sin_mag = sin_v[CW-1] ? 32'(-sin_v) : 32'(sin_v);
    rmag[0] = cside[CORDIC_STAGES].rot_x[31] ? 32'(-cside[CORDIC_STAGES].rot_x)
                                             : 32'(cside[CORDIC_STAGES].rot_x);
    rmag[1] = cside[CORDIC_STAGES].rot_y[31] ? 32'(-cside[CORDIC_STAGES].rot_y)
                                             : 32'(cside[CORDIC_STAGES].rot_y);
    rmag[2] = cside[CORDIC_STAGES].rot_z[31] ? 32'(-cside[CORDIC_STAGES].rot_z)
                                             : 32'(cside[CORDIC_STAGES].rot_z);
    rneg[0] = (cside[CORDIC_STAGES].rot_x[31] != sin_v[CW-1]);
    rneg[1] = (cside[CORDIC_STAGES].rot_y[31] != sin_v[CW-1]);
    rneg[2] = (cside[CORDIC_STAGES].rot_z[31] != sin_v[CW-1]);
  end

  logic              mp_valid_q, mp_zero_q;
  logic [2:0][NW-1:0] mp_num_q;
  logic [2:0]        mp_neg_q;
  logic [RW-1:0]     mp_n_q;
  logic [CW-1:0]     mp_w_q;
  r2q_pkg::side_t    mp_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_valid_q <= 1'b0;
    end else if (en) begin
      mp_valid_q <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        mp_num_q[c] <= rmag[c] * sin_mag;
      end
      mp_neg_q  <= rneg;
      mp_n_q    <= cn[CORDIC_STAGES];
      mp_w_q    <= w_sat;
      mp_zero_q <= (cn[CORDIC_STAGES] == '0);
      mp_side_q <= cside[CORDIC_STAGES];
    end
  end

  // Rounding: add n/2 to the numerator before division
  logic              rd_valid_q, rd_zero_q;
  logic [2:0][NW-1:0] rd_num_q;
  logic [2:0]        rd_neg_q;
  logic [RW-1:0]     rd_n_q;
  logic [CW-1:0]     rd_w_q;
  r2q_pkg::side_t    rd_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (en) begin
      rd_valid_q <= mp_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rd_num_q[c] <= mp_num_q[c] + NW'(mp_n_q >> 1);
      end
      rd_neg_q  <= mp_neg_q;
      rd_n_q    <= mp_n_q;
      rd_w_q    <= mp_w_q;
      rd_zero_q <= mp_zero_q;
      rd_side_q <= mp_side_q;
    end
  end

  // ---------------- Divider chain ----------------
  logic [NW:0]                 dv, dzero;
  logic [NW:0][RW-1:0]         dn;
  logic [NW:0][2:0][NW:0]      drem;
  logic [NW:0][2:0][NW-1:0]    dnum, dquo;
  logic [NW:0][2:0]            dneg;
  logic [NW:0][CW-1:0]         dw;
  r2q_pkg::side_t [NW:0]       dside;

  assign dv[0]    = rd_valid_q;
  assign dzero[0] = rd_zero_q;
  assign dn[0]    = rd_n_q;
  assign drem[0]  = '0;
  assign dnum[0]  = rd_num_q;
  assign dquo[0]  = '0;
  assign dneg[0]  = rd_neg_q;
  assign dw[0]    = rd_w_q;
  assign dside[0] = rd_side_q;

  for (genvar g = 0; g < NW; g++) begin : g_div
    r2q_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(dv[g]), .n_i(dn[g]), .rem_i(drem[g]), .num_i(dnum[g]), .quo_i(dquo[g]),
      .neg_i(dneg[g]), .w_i(dw[g]), .zero_i(dzero[g]), .side_i(dside[g]),
      .valid_o(dv[g+1]), .n_o(dn[g+1]), .rem_o(drem[g+1]), .num_o(dnum[g+1]),
      .quo_o(dquo[g+1]), .neg_o(dneg[g+1]), .w_o(dw[g+1]), .zero_o(dzero[g+1]),
      .side_o(dside[g+1])
    );
  end

  // ---------------- Sign, saturation and output register ----------------
  logic [2:0][31:0] qv;
  logic [31:0]      qw;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dzero[NW]) begin
        qv[c] = '0;
      end else if (dquo[NW][c] > NW'(r2q_pkg::ONE_Q30)) begin
        qv[c] = dneg[NW][c] ? 32'(-r2q_pkg::ONE_Q30) : 32'(r2q_pkg::ONE_Q30);
      end else begin
        qv[c] = dneg[NW][c] ? 32'(-dquo[NW][c]) : 32'(dquo[NW][c]);
      end
    end
    qw = dzero[NW] ? 32'(r2q_pkg::ONE_Q30) : dw[NW][31:0];
  end

  logic [223:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {qw, qv[2], qv[1], qv[0],
                dside[NW].trans_z, dside[NW].trans_y, dside[NW].trans_x};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // ---------------- Assertions ----------------
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_wmag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[223:192]) <= 32'sd1073741824 &&
                       $signed(m_axis_tdata[223:192]) >= -32'sd1073741824))
    else $error("quat_w out of range");
  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && dv[NW] && dzero[NW] |=> m_axis_tdata[223:192] == 32'd1073741824)
    else $error("zero angle not identity");

endmodule
